[hdl/owsv_pkg.sv]
package owsv_pkg;

    localparam int NumWheels   = 4;
    localparam int NumRegs     = 8;
    localparam int AddrW       = 5;
    localparam int OmegaGainQ14 = 1024;
    localparam int OneQ14      = 16384;
    localparam int ScaleNum    = 1000;
    localparam int ScaleDen    = 1001;
    localparam int FracShift   = 11;

    // Magnitudes stay below 2^21 before and after every rescale.
    localparam int MagW      = 21;
    localparam int SpdW      = MagW + 1;
    localparam int ProdW     = 32;
    localparam int SumW      = 34;
    localparam int NumW      = 31;          // magnitude times ScaleNum
    localparam int DenW      = 31;          // magnitude times ScaleDen
    localparam int RemW      = DenW + 1;
    localparam int QuoW      = 22;
    localparam int DivBits   = 2;
    localparam int DivStages = QuoW / DivBits;
    localparam int OneShift  = 14;          // numerator is (mag*1000) << 14
    localparam int InitW     = NumW + OneShift - QuoW;

    typedef logic signed [SpdW-1:0] t_spd;
    typedef t_spd [NumWheels-1:0] t_spd_vec;
    typedef logic [MagW-1:0] t_mag;
    typedef logic [NumRegs-1:0][31:0] t_dir_vec;

    typedef struct packed {
        logic [RemW-1:0] rem;
        logic            qbit;
    } t_div;

    // One restoring step: shift in a numerator bit, subtract when it fits.
    function automatic t_div div_step(input logic [RemW-1:0] rem, input logic nbit,
                                      input logic [DenW-1:0] den);
        t_div            res;
        logic [RemW-1:0] t;
        t = {rem[RemW-2:0], nbit};
        if (t >= {1'b0, den}) begin
            res.rem  = t - {1'b0, den};
            res.qbit = 1'b1;
        end else begin
            res.rem  = t;
            res.qbit = 1'b0;
        end
        return res;
    endfunction

endpackage

[hdl/owsv_cmd_if.sv]
interface owsv_cmd_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_turn;
    logic               use_new_angles;

    modport source (output valid, vel_x, vel_y, vel_turn, use_new_angles, input ready);
    modport sink   (input valid, vel_x, vel_y, vel_turn, use_new_angles, output ready);
endinterface

[hdl/owsv_spd_if.sv]
interface owsv_spd_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] wheel1_speed;
    logic signed [15:0] wheel2_speed;
    logic signed [15:0] wheel3_speed;
    logic signed [15:0] wheel4_speed;
    logic               was_rescaled;

    modport source (output valid, wheel1_speed, wheel2_speed, wheel3_speed, wheel4_speed,
                    was_rescaled, input ready);
    modport sink   (input valid, wheel1_speed, wheel2_speed, wheel3_speed, wheel4_speed,
                    was_rescaled, output ready);
endinterface

[hdl/owsv_cfg.sv]
module owsv_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [owsv_pkg::AddrW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output owsv_pkg::t_dir_vec          o_dir
);
    owsv_pkg::t_dir_vec r_dir;
    logic [2:0]         w_idx;

    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign prdata = r_dir[w_idx];
    assign o_dir  = r_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= '0;
        end else if (psel && penable && pwrite) begin
            r_dir[w_idx] <= pwdata;
        end
    end
endmodule

[hdl/owsv_front.sv]
module owsv_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [15:0]  i_vel_x,
    input  logic signed [15:0]  i_vel_y,
    input  logic signed [15:0]  i_vel_turn,
    input  logic                i_use_new,
    input  owsv_pkg::t_dir_vec  i_dir,
    output logic                o_valid,
    output owsv_pkg::t_spd_vec  o_spd
);
    localparam logic signed [16:0] GainS = 17'(owsv_pkg::OmegaGainQ14);

    logic [2:0]         r_valid;
    logic signed [15:0] r1_vx, r1_vy, r1_vt;
    logic signed [15:0] r1_cos [owsv_pkg::NumWheels];
    logic signed [15:0] r1_sin [owsv_pkg::NumWheels];
    logic signed [owsv_pkg::ProdW-1:0] r2_pc [owsv_pkg::NumWheels];
    logic signed [owsv_pkg::ProdW-1:0] r2_ps [owsv_pkg::NumWheels];
    logic signed [owsv_pkg::ProdW:0]   r2_pt;
    owsv_pkg::t_spd_vec r3_spd;
    owsv_pkg::t_spd_vec n3_spd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_vx <= i_vel_x;
            r1_vy <= i_vel_y;
            r1_vt <= i_vel_turn;
            for (int w = 0; w < owsv_pkg::NumWheels; w++) begin
                r1_cos[w] <= i_use_new ? i_dir[w][31:16]
                                       : i_dir[w + owsv_pkg::NumWheels][31:16];
                r1_sin[w] <= i_use_new ? i_dir[w][15:0]
                                       : i_dir[w + owsv_pkg::NumWheels][15:0];
                r2_pc[w]  <= r1_cos[w] * r1_vx;
                r2_ps[w]  <= r1_sin[w] * r1_vy;
            end
            r2_pt  <= r1_vt * GainS;
            r3_spd <= n3_spd;
        end
    end

    // Sum in Q.25, then truncate toward zero into Q.14.
    always_comb begin
        logic signed [owsv_pkg::SumW-1:0] sum;
        logic [owsv_pkg::SumW-1:0]        mag;
        logic [owsv_pkg::SpdW-1:0]        sh;
        n3_spd = '0;
        for (int w = 0; w < owsv_pkg::NumWheels; w++) begin
            sum = owsv_pkg::SumW'(r2_pc[w]) + owsv_pkg::SumW'(r2_ps[w])
                + owsv_pkg::SumW'(r2_pt);
            mag = sum[owsv_pkg::SumW-1] ? -sum : sum;
            sh  = owsv_pkg::SpdW'(mag >> owsv_pkg::FracShift);
            n3_spd[w] = sum[owsv_pkg::SumW-1] ? -$signed(sh) : $signed(sh);
        end
    end

    assign o_valid = r_valid[2];
    assign o_spd   = r3_spd;
endmodule

[hdl/owsv_check.sv]
module owsv_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [1:0]         i_wheel,
    input  logic               i_valid,
    input  owsv_pkg::t_spd_vec i_spd,
    input  logic               i_scaled,
    output logic               o_valid,
    output owsv_pkg::t_spd_vec o_spd,
    output logic               o_scaled
);
    localparam int Nw = owsv_pkg::NumWheels;
    localparam int Ds = owsv_pkg::DivStages;

    logic [Ds+2:0] r_valid;

    // Stage A: magnitudes and signs.
    owsv_pkg::t_spd_vec r_a_spd;
    owsv_pkg::t_mag     r_a_mag [Nw];
    logic               r_a_scaled;

    // Stage B: divisor, numerators and the rescale decision.
    owsv_pkg::t_spd_vec           r_b_spd;
    logic [owsv_pkg::NumW-1:0]    r_b_num [Nw];
    logic [owsv_pkg::DenW-1:0]    r_b_den;
    logic                         r_b_do;
    logic                         r_b_scaled;

    // Divider stages, two quotient bits each.
    logic [owsv_pkg::RemW-1:0]    r_rem [Ds][Nw];
    logic [owsv_pkg::QuoW-1:0]    r_low [Ds][Nw];
    logic [owsv_pkg::QuoW-1:0]    r_quo [Ds][Nw];
    logic [owsv_pkg::QuoW-1:0]    n_rem_l [Ds][Nw];
    logic [owsv_pkg::RemW-1:0]    n_rem [Ds][Nw];
    logic [owsv_pkg::QuoW-1:0]    n_quo [Ds][Nw];
    owsv_pkg::t_spd_vec           r_d_spd [Ds];
    logic [owsv_pkg::DenW-1:0]    r_d_den [Ds];
    logic                         r_d_do [Ds];
    logic                         r_d_scaled [Ds];

    owsv_pkg::t_spd_vec r_f_spd;
    logic               r_f_scaled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[Ds+1:0], i_valid};
        end
    end

    always_comb begin
        owsv_pkg::t_div            st;
        logic [owsv_pkg::RemW-1:0] rem;
        logic [owsv_pkg::QuoW-1:0] low;
        logic [owsv_pkg::QuoW-1:0] quo;
        logic [owsv_pkg::DenW-1:0] den;
        for (int k = 0; k < Ds; k++) begin
            for (int w = 0; w < Nw; w++) begin
                if (k == 0) begin
                    rem = owsv_pkg::RemW'(r_b_num[w] >> (owsv_pkg::QuoW - owsv_pkg::OneShift));
                    low = {r_b_num[w][owsv_pkg::QuoW-owsv_pkg::OneShift-1:0],
                           owsv_pkg::OneShift'(0)};
                    quo = '0;
                    den = r_b_den;
                end else begin
                    rem = r_rem[k-1][w];
                    low = r_low[k-1][w];
                    quo = r_quo[k-1][w];
                    den = r_d_den[k-1];
                end
                for (int b = 0; b < owsv_pkg::DivBits; b++) begin
                    st  = owsv_pkg::div_step(rem, low[owsv_pkg::QuoW-1], den);
                    rem = st.rem;
                    low = low << 1;
                    quo = {quo[owsv_pkg::QuoW-2:0], st.qbit};
                end
                n_rem[k][w]   = rem;
                n_rem_l[k][w] = low;
                n_quo[k][w]   = quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_spd    <= i_spd;
            r_a_scaled <= i_scaled;
            for (int w = 0; w < Nw; w++) begin
                r_a_mag[w] <= owsv_pkg::MagW'(i_spd[w][owsv_pkg::SpdW-1] ? -i_spd[w] : i_spd[w]);
                r_b_num[w] <= owsv_pkg::NumW'(r_a_mag[w]) * owsv_pkg::NumW'(owsv_pkg::ScaleNum);
            end
            r_b_spd    <= r_a_spd;
            r_b_scaled <= r_a_scaled;
            r_b_den    <= owsv_pkg::DenW'(r_a_mag[i_wheel])
                        * owsv_pkg::DenW'(owsv_pkg::ScaleDen);
            r_b_do     <= r_a_mag[i_wheel] > owsv_pkg::MagW'(owsv_pkg::OneQ14);
            for (int k = 0; k < Ds; k++) begin
                r_rem[k] <= n_rem[k];
                r_low[k] <= n_rem_l[k];
                r_quo[k] <= n_quo[k];
                if (k == 0) begin
                    r_d_spd[k]    <= r_b_spd;
                    r_d_den[k]    <= r_b_den;
                    r_d_do[k]     <= r_b_do;
                    r_d_scaled[k] <= r_b_scaled;
                end else begin
                    r_d_spd[k]    <= r_d_spd[k-1];
                    r_d_den[k]    <= r_d_den[k-1];
                    r_d_do[k]     <= r_d_do[k-1];
                    r_d_scaled[k] <= r_d_scaled[k-1];
                end
            end
            // The quotient carries the sign of the speed it came from.
            for (int w = 0; w < Nw; w++) begin
                if (r_d_do[Ds-1]) begin
                    r_f_spd[w] <= r_d_spd[Ds-1][w][owsv_pkg::SpdW-1]
                                ? -$signed(r_quo[Ds-1][w]) : $signed(r_quo[Ds-1][w]);
                end else begin
                    r_f_spd[w] <= r_d_spd[Ds-1][w];
                end
            end
            r_f_scaled <= r_d_scaled[Ds-1] | r_d_do[Ds-1];
        end
    end

    assign o_valid  = r_valid[Ds+2];
    assign o_spd    = r_f_spd;
    assign o_scaled = r_f_scaled;
endmodule

[hdl/omni_wheel_speed_from_body_velocity.sv]
// One command is accepted per cycle while the output is not stalled.
// The pipeline has 3 front stages and 14 stages per wheel check.
// Each check runs four 2-bit-per-stage restoring dividers over 11 stages.
// A stall at the output holds the whole pipeline in place.
// Reset (synchronous, active low) clears all valid bits and the direction registers.
// The datapath registers are not reset.
module omni_wheel_speed_from_body_velocity (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [owsv_pkg::AddrW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    owsv_cmd_if.sink                   i_cmd,
    owsv_spd_if.source                 o_spd
);
    // The pipeline moves as one: it advances whenever the output register
    // is empty or its transaction is being taken this cycle.
    logic               w_en;
    owsv_pkg::t_dir_vec w_dir;

    logic               w_valid [owsv_pkg::NumWheels+1];
    owsv_pkg::t_spd_vec w_spd   [owsv_pkg::NumWheels+1];
    logic               w_scl   [owsv_pkg::NumWheels+1];

    assign w_en        = !w_valid[owsv_pkg::NumWheels] || o_spd.ready;
    assign i_cmd.ready = w_en;

    owsv_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_dir   (w_dir)
    );

    // Projection of the body velocity onto each wheel direction.
    owsv_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_cmd.valid),
        .i_vel_x    (i_cmd.vel_x),
        .i_vel_y    (i_cmd.vel_y),
        .i_vel_turn (i_cmd.vel_turn),
        .i_use_new  (i_cmd.use_new_angles),
        .i_dir      (w_dir),
        .o_valid    (w_valid[0]),
        .o_spd      (w_spd[0])
    );

    assign w_scl[0] = 1'b0;

    // Wheels are checked in order; each check sees the speeds left by the
    // one before it, so the checks are chained stages.
    for (genvar g = 0; g < owsv_pkg::NumWheels; g++) begin : g_check
        owsv_check u_check (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_wheel  (2'(g)),
            .i_valid  (w_valid[g]),
            .i_spd    (w_spd[g]),
            .i_scaled (w_scl[g]),
            .o_valid  (w_valid[g+1]),
            .o_spd    (w_spd[g+1]),
            .o_scaled (w_scl[g+1])
        );
    end

    assign o_spd.valid        = w_valid[owsv_pkg::NumWheels];
    assign o_spd.wheel1_speed = 16'(w_spd[owsv_pkg::NumWheels][0]);
    assign o_spd.wheel2_speed = 16'(w_spd[owsv_pkg::NumWheels][1]);
    assign o_spd.wheel3_speed = 16'(w_spd[owsv_pkg::NumWheels][2]);
    assign o_spd.wheel4_speed = 16'(w_spd[owsv_pkg::NumWheels][3]);
    assign o_spd.was_rescaled = w_scl[owsv_pkg::NumWheels];
endmodule

[tb/omni_wheel_speed_from_body_velocity_tb.sv]
`timescale 1ns / 100ps

module omni_wheel_speed_from_body_velocity_tb;

    // Register indexes of the direction set, in the block's address order.
    typedef enum int {
        RegW1New = 0, RegW2New, RegW3New, RegW4New,
        RegW1Old, RegW2Old, RegW3Old, RegW4Old
    } t_reg_idx;

    // One expected wheel-speed transaction.
    typedef struct {
        logic signed [15:0] spd [4];
        logic               rescaled;
    } t_wheel_result;

    // Covers the block's pipeline latency, plus margin for the drain.
    localparam int DrainCycles = 80;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [owsv_pkg::AddrW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    owsv_cmd_if cmd_bus ();
    owsv_spd_if spd_bus ();

    omni_wheel_speed_from_body_velocity u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_cmd   (cmd_bus.sink),
        .o_spd   (spd_bus.source)
    );

    // Shadow copy of the direction registers, used by the speed predictor.
    logic [31:0] dir_shadow [owsv_pkg::NumRegs];

    t_wheel_result expected_speeds [$];
    int error_count = 0;
    int cmd_count = 0;
    int result_count = 0;
    int rescale_count = 0;

    // Receiver stall control. A nonzero hold count forces ready low until it
    // counts down to zero, which lets the pipeline fill and back up into the input.
    int spd_hold_cycles = 0;

    // Sender burst control.
    bit cmd_gaps_enable = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Computes the four normalized wheel speeds for one velocity command, using
    // the shadow direction set that the command selects. Each wheel above one
    // rescales all four, and later checks see the rescaled values.
    function automatic t_wheel_result predict_wheel_speeds(
            input logic signed [15:0] vx, input logic signed [15:0] vy,
            input logic signed [15:0] vt, input logic use_new);
        t_wheel_result res;
        longint        spd [4];
        longint        sum;
        longint        mag;
        longint        den;
        logic [31:0]   dir;
        logic signed [15:0] cosv;
        logic signed [15:0] sinv;
        int            base;
        base = use_new ? RegW1New : RegW1Old;
        res.rescaled = 1'b0;
        for (int w = 0; w < 4; w++) begin
            dir  = dir_shadow[base + w];
            cosv = dir[31:16];
            sinv = dir[15:0];
            sum = longint'(cosv) * vx + longint'(sinv) * vy
                + longint'(owsv_pkg::OmegaGainQ14) * vt;
            // Truncate toward zero from Q.25 to Q.14.
            mag = (sum < 0) ? -sum : sum;
            mag = mag >>> owsv_pkg::FracShift;
            spd[w] = (sum < 0) ? -mag : mag;
        end
        for (int w = 0; w < 4; w++) begin
            mag = (spd[w] < 0) ? -spd[w] : spd[w];
            if (mag > owsv_pkg::OneQ14) begin
                den = mag * owsv_pkg::ScaleDen;
                res.rescaled = 1'b1;
                // SystemVerilog division on longint truncates toward zero.
                for (int k = 0; k < 4; k++)
                    spd[k] = (spd[k] * owsv_pkg::OneQ14 * owsv_pkg::ScaleNum) / den;
            end
        end
        for (int w = 0; w < 4; w++)
            res.spd[w] = spd[w][15:0];
        return res;
    endfunction

    // APB write: a setup phase then an access phase. The register takes the
    // value at the rising edge where psel, penable, pwrite and pready are high.
    task automatic write_dir_reg(input int idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= owsv_pkg::AddrW'(idx * 4);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < owsv_pkg::NumRegs)
            dir_shadow[idx] = value;
    endtask

    // Reads back one register and compares it with the shadow copy.
    task automatic check_dir_reg(input int idx);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= owsv_pkg::AddrW'(idx * 4);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== dir_shadow[idx]) begin
            $error("dir_reg[%0d]: expected %h, actual %h", idx, dir_shadow[idx], prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offers one velocity command, with a random gap ahead of it when gaps are
    // enabled, and waits until the block accepts the transaction. valid stays
    // high across back-to-back commands, so it is never lowered and raised in
    // the same step.
    task automatic send_velocity(input logic signed [15:0] vx, input logic signed [15:0] vy,
                                 input logic signed [15:0] vt, input logic use_new);
        int gap;
        gap = 0;
        if (cmd_gaps_enable && ($urandom_range(0, 3) == 0))
            gap = $urandom_range(1, 6);
        if (gap > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_bus.valid          <= 1'b1;
        cmd_bus.vel_x          <= vx;
        cmd_bus.vel_y          <= vy;
        cmd_bus.vel_turn       <= vt;
        cmd_bus.use_new_angles <= use_new;
        do @(posedge i_clk); while (!cmd_bus.ready);
        expected_speeds.push_back(predict_wheel_speeds(vx, vy, vt, use_new));
        cmd_count++;
        @(negedge i_clk);
    endtask

    task automatic end_command_burst();
        cmd_bus.valid <= 1'b0;
    endtask

    // Waits for every expected result, then lets the pipeline settle so that a
    // register write cannot catch a command still in flight.
    task automatic wait_idle();
        end_command_burst();
        while (expected_speeds.size() != 0)
            @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pack_dir(input logic signed [15:0] cosv,
                                             input logic signed [15:0] sinv);
        return {cosv, sinv};
    endfunction

    // Typical omni layout: unit vectors at 45, 135, 225 and 315 degrees.
    task automatic load_unit_directions(input bit use_new);
        int base;
        base = use_new ? RegW1New : RegW1Old;
        write_dir_reg(base + 0, pack_dir(16'sd11585, 16'sd11585));
        write_dir_reg(base + 1, pack_dir(-16'sd11585, 16'sd11585));
        write_dir_reg(base + 2, pack_dir(-16'sd11585, -16'sd11585));
        write_dir_reg(base + 3, pack_dir(16'sd11585, -16'sd11585));
    endtask

    function automatic logic signed [15:0] random_velocity();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(signed'($urandom_range(0, 4096)) - 2048);
            default: return 16'($urandom);
        endcase
    endfunction

    // Commands against registers still at their reset value of zero: only the
    // turn term contributes. The full negative turn rate gives every wheel a
    // magnitude of exactly one, which must not rescale.
    task automatic test_reset_registers();
        for (int i = 0; i < owsv_pkg::NumRegs; i++)
            check_dir_reg(i);
        send_velocity(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
        send_velocity(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
        send_velocity(16'sd0, 16'sd0, 16'sd0, 1'b1);
        wait_idle();
    endtask

    // Directed points: field extremes, both angle sets, a magnitude of exactly
    // one from a pure negative full-scale turn, and magnitudes above one.
    task automatic test_directed();
        load_unit_directions(1'b1);
        write_dir_reg(RegW1Old, pack_dir(16'sh7FFF, 16'sh8000));
        write_dir_reg(RegW2Old, pack_dir(16'sh8000, 16'sh8000));
        write_dir_reg(RegW3Old, pack_dir(16'sh4000, 16'sh0000));
        write_dir_reg(RegW4Old, pack_dir(16'sh0000, 16'sh4000));
        for (int i = 0; i < owsv_pkg::NumRegs; i++)
            check_dir_reg(i);
        // Old wheel 3 is one times vel_x; 2048 in Q4.11 is 1.0, so these
        // values drive it to about two, and old wheels 1 and 2 further.
        send_velocity(16'sd4096, 16'sd0, 16'sd0, 1'b0);
        send_velocity(16'sd4097, 16'sd0, 16'sd0, 1'b0);
        send_velocity(-16'sd4096, 16'sd0, 16'sd0, 1'b0);
        send_velocity(16'sd0, 16'sd4097, 16'sd0, 1'b0);
        send_velocity(16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0);
        send_velocity(16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0);
        send_velocity(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
        send_velocity(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
        send_velocity(16'sd100, -16'sd100, 16'sd50, 1'b1);
        send_velocity(16'sd2048, 16'sd0, 16'sd0, 1'b1);
        send_velocity(16'sh7FFF, 16'sd0, 16'sd0, 1'b1);
        send_velocity(16'sh8000, 16'sh8000, 16'sd0, 1'b1);
        send_velocity(16'sd0, 16'sd0, 16'sh7FFF, 1'b1);
        send_velocity(16'sd0, 16'sd0, 16'sh8000, 1'b1);
        send_velocity(-16'sd1, -16'sd1, -16'sd1, 1'b1);
        wait_idle();
    endtask

    // Random commands over random direction sets. Before each phase the
    // registers are rewritten while the block is idle, including full-scale
    // patterns that do not form a unit vector.
    task automatic test_random_commands(input int num_cmds);
        int per_phase;
        per_phase = num_cmds / 5;
        for (int p = 0; p < 5; p++) begin
            for (int i = 0; i < owsv_pkg::NumRegs; i++) begin
                case ($urandom_range(0, 3))
                    0: write_dir_reg(i, 32'hFFFF_FFFF);
                    1: write_dir_reg(i, 32'h8000_7FFF);
                    default: write_dir_reg(i, $urandom);
                endcase
            end
            if (p == 0)
                load_unit_directions(1'b0);
            for (int n = 0; n < per_phase; n++)
                send_velocity(random_velocity(), random_velocity(), random_velocity(),
                              1'($urandom_range(0, 1)));
            wait_idle();
        end
    endtask

    // Holds the receiver off long enough for the pipeline to fill, while the
    // sender keeps offering back-to-back commands.
    task automatic test_backpressure();
        load_unit_directions(1'b1);
        cmd_gaps_enable = 1'b0;
        spd_hold_cycles = 150;
        for (int n = 0; n < 90; n++)
            send_velocity(random_velocity(), random_velocity(), random_velocity(), 1'b1);
        cmd_gaps_enable = 1'b1;
        wait_idle();
    endtask

    // Receiver: a random stall pattern, with stretches of none, plus the
    // long hold-off requested by the back-pressure test.
    initial begin
        int pattern;
        int stretch;
        spd_bus.ready <= 1'b0;
        pattern = 0;
        stretch = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (spd_hold_cycles > 0) begin
                spd_bus.ready <= 1'b0;
                spd_hold_cycles--;
            end else begin
                if (stretch == 0) begin
                    pattern = $urandom_range(0, 3);
                    stretch = $urandom_range(10, 60);
                end
                stretch--;
                case (pattern)
                    0: spd_bus.ready <= 1'b1;
                    1: spd_bus.ready <= ($urandom_range(0, 1) == 0);
                    2: spd_bus.ready <= ($urandom_range(0, 4) != 0);
                    default: spd_bus.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Result checker: each accepted transaction is compared with the oldest
    // expectation, field by field.
    initial begin
        t_wheel_result exp_res;
        logic signed [15:0] act [4];
        forever begin
            @(posedge i_clk);
            if (i_rst_n && spd_bus.valid && spd_bus.ready) begin
                act[0] = spd_bus.wheel1_speed;
                act[1] = spd_bus.wheel2_speed;
                act[2] = spd_bus.wheel3_speed;
                act[3] = spd_bus.wheel4_speed;
                if (expected_speeds.size() == 0) begin
                    $error("unexpected wheel speed transaction");
                    error_count++;
                end else begin
                    exp_res = expected_speeds.pop_front();
                    result_count++;
                    if (exp_res.rescaled)
                        rescale_count++;
                    for (int w = 0; w < 4; w++) begin
                        if (act[w] !== exp_res.spd[w]) begin
                            $error("wheel%0d_speed: expected %0d, actual %0d",
                                   w + 1, exp_res.spd[w], act[w]);
                            error_count++;
                        end
                    end
                    if (spd_bus.was_rescaled !== exp_res.rescaled) begin
                        $error("was_rescaled: expected %0b, actual %0b",
                               exp_res.rescaled, spd_bus.was_rescaled);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: far beyond the slowest correct run of the whole sequence.
    initial begin
        #4_000_000;
        $display("FAIL omni_wheel_speed_from_body_velocity");
        $finish;
    end

    initial begin
        i_rst_n                = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        cmd_bus.valid          = 1'b0;
        cmd_bus.vel_x          = '0;
        cmd_bus.vel_y          = '0;
        cmd_bus.vel_turn       = '0;
        cmd_bus.use_new_angles = 1'b0;
        for (int i = 0; i < owsv_pkg::NumRegs; i++)
            dir_shadow[i] = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_registers();
        test_directed();
        test_random_commands(400);
        test_backpressure();

        // Final pause so that no stray transaction can slip in unnoticed.
        end_command_burst();
        repeat (DrainCycles) @(negedge i_clk);
        if (expected_speeds.size() != 0) begin
            $error("%0d wheel speed transactions never arrived", expected_speeds.size());
            error_count++;
        end
        $display("Ran %0d velocity commands over several direction sets; %0d results checked.",
                 cmd_count, result_count);
        $display("%0d results were rescaled; long output stall and idle pauses exercised.",
                 rescale_count);
        if (error_count == 0) begin
            $display("PASS omni_wheel_speed_from_body_velocity");
        end else begin
            $display("FAIL omni_wheel_speed_from_body_velocity");
        end
        $finish;
    end

endmodule
